[design/wcs_pkg.sv]
// ----------------------------------------------------------------------------
// wcs_pkg
// Types and character codes shared by the whitespace and comment skipper.
// ----------------------------------------------------------------------------
package wcs_pkg;

    localparam int unsigned FIELD_OFFSET_BITS = 32;

    localparam logic [7:0] C_SPACE     = 8'h20;
    localparam logic [7:0] C_TAB       = 8'h09;
    localparam logic [7:0] C_CR        = 8'h0D;
    localparam logic [7:0] C_FF        = 8'h0C;
    localparam logic [7:0] C_VT        = 8'h0B;
    localparam logic [7:0] C_NL        = 8'h0A;
    localparam logic [7:0] C_SLASH     = 8'h2F;
    localparam logic [7:0] C_STAR      = 8'h2A;
    localparam logic [7:0] C_BACKSLASH = 8'h5C;

    typedef enum logic [2:0] {
        MODE_WS         = 3'd0,
        MODE_SLASH      = 3'd1,
        MODE_LINE       = 3'd2,
        MODE_LINE_BS    = 3'd3,
        MODE_BLOCK      = 3'd4,
        MODE_BLOCK_STAR = 3'd5
    } t_mode;

    typedef struct packed {
        logic [7:0]                   text_byte;
        logic                         first_byte;
        logic [FIELD_OFFSET_BITS-1:0] start_offset;
        logic                         last_byte;
    } t_item;

    typedef struct packed {
        logic                         valid;
        t_item                        item;
    } t_in_word;

    typedef struct packed {
        logic                         emit;
        // the held byte would give a result if stepped
        logic                         emit_hold;
        logic [FIELD_OFFSET_BITS-1:0] stop_offset;
        logic                         unclosed_comment;
    } t_result;

endpackage

[design/wcs_in_stage.sv]
// ----------------------------------------------------------------------------
// wcs_in_stage
// Input register: holds one text word until the scanner consumes it.
// ----------------------------------------------------------------------------
module wcs_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  wcs_pkg::t_item   i_item,
    input  logic             i_advance,
    output wcs_pkg::t_in_word o_word
);

    logic           r_valid;
    wcs_pkg::t_item r_item;
    logic           take;

    // free when empty or when the held word moves on this cycle
    assign o_stall = r_valid && !i_advance;
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_item;
        end
    end

    assign o_word.valid = r_valid;
    assign o_word.item  = r_item;

endmodule

[design/wcs_scan_core.sv]
// ----------------------------------------------------------------------------
// wcs_scan_core
// Scan mode machine: one text byte per step, gives the stop position.
// ----------------------------------------------------------------------------
module wcs_scan_core #(
    parameter int unsigned OFFSET_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  wcs_pkg::t_item    i_item,
    input  logic              i_skip_nl,
    output wcs_pkg::t_result  o_result
);

    localparam int unsigned FB = wcs_pkg::FIELD_OFFSET_BITS;

    wcs_pkg::t_mode          r_mode, n_mode;
    logic [OFFSET_BITS-1:0]  r_cur_offset, n_cur_offset;
    logic                    r_done, n_done;

    wcs_pkg::t_mode          mode_eff;
    logic                    done_eff;
    logic [OFFSET_BITS-1:0]  start_ofs;
    logic [OFFSET_BITS-1:0]  cur_eff;
    logic [OFFSET_BITS-1:0]  pos_end;
    logic [OFFSET_BITS-1:0]  pos_prev;
    logic [OFFSET_BITS-1:0]  stop_pos;
    logic [OFFSET_BITS+FB-1:0] start_ext;
    logic [OFFSET_BITS+FB-1:0] stop_ext;
    logic [7:0]              c;
    logic                    last;
    logic                    blank;
    logic                    emit_raw;
    logic                    unclosed;

    assign c    = i_item.text_byte;
    assign last = i_item.last_byte;

    // resize between field width and offset width in either direction
    assign start_ext = {{OFFSET_BITS{1'b0}}, i_item.start_offset};
    assign start_ofs = start_ext[OFFSET_BITS-1:0];

    assign mode_eff = i_item.first_byte ? wcs_pkg::MODE_WS : r_mode;
    assign done_eff = i_item.first_byte ? 1'b0 : r_done;
    assign cur_eff  = i_item.first_byte ? start_ofs : r_cur_offset;
    assign pos_end  = cur_eff + 1'b1;
    assign pos_prev = cur_eff - 1'b1;

    assign blank = (c == wcs_pkg::C_SPACE) || (c == wcs_pkg::C_TAB) ||
                   (c == wcs_pkg::C_CR) || (c == wcs_pkg::C_FF) ||
                   (c == wcs_pkg::C_VT) || ((c == wcs_pkg::C_NL) && i_skip_nl);

    // next mode
    always_comb begin
        n_mode = mode_eff;
        if (!done_eff) begin
            case (mode_eff)
                wcs_pkg::MODE_SLASH: begin
                    if (c == wcs_pkg::C_SLASH) begin
                        n_mode = wcs_pkg::MODE_LINE;
                    end else if (c == wcs_pkg::C_STAR) begin
                        n_mode = wcs_pkg::MODE_BLOCK;
                    end
                end
                wcs_pkg::MODE_LINE, wcs_pkg::MODE_LINE_BS: begin
                    if (c == wcs_pkg::C_NL) begin
                        if (mode_eff == wcs_pkg::MODE_LINE_BS) begin
                            n_mode = wcs_pkg::MODE_LINE;
                        end else if (i_skip_nl) begin
                            n_mode = wcs_pkg::MODE_WS;
                        end
                    end else if (c == wcs_pkg::C_BACKSLASH) begin
                        n_mode = wcs_pkg::MODE_LINE_BS;
                    end else begin
                        n_mode = wcs_pkg::MODE_LINE;
                    end
                end
                wcs_pkg::MODE_BLOCK, wcs_pkg::MODE_BLOCK_STAR: begin
                    if (c == wcs_pkg::C_SLASH && mode_eff == wcs_pkg::MODE_BLOCK_STAR) begin
                        n_mode = wcs_pkg::MODE_WS;
                    end else if (c == wcs_pkg::C_STAR) begin
                        n_mode = wcs_pkg::MODE_BLOCK_STAR;
                    end else begin
                        n_mode = wcs_pkg::MODE_BLOCK;
                    end
                end
                default: begin
                    // whitespace mode, and unused codes fall back to it
                    if (!blank && c == wcs_pkg::C_SLASH && !last) begin
                        n_mode = wcs_pkg::MODE_SLASH;
                    end else begin
                        n_mode = wcs_pkg::MODE_WS;
                    end
                end
            endcase
        end
    end

    // result of this byte
    always_comb begin
        emit_raw = last;
        stop_pos = pos_end;
        unclosed = 1'b0;
        case (mode_eff)
            wcs_pkg::MODE_SLASH: begin
                if (c == wcs_pkg::C_STAR) begin
                    unclosed = 1'b1;
                end else if (c != wcs_pkg::C_SLASH) begin
                    // lone slash: stop back at the slash itself
                    emit_raw = 1'b1;
                    stop_pos = pos_prev;
                end
            end
            wcs_pkg::MODE_LINE, wcs_pkg::MODE_LINE_BS: begin
                if (c == wcs_pkg::C_NL && mode_eff == wcs_pkg::MODE_LINE && !i_skip_nl) begin
                    emit_raw = 1'b1;
                    stop_pos = cur_eff;
                end
            end
            wcs_pkg::MODE_BLOCK, wcs_pkg::MODE_BLOCK_STAR: begin
                if (!(c == wcs_pkg::C_SLASH && mode_eff == wcs_pkg::MODE_BLOCK_STAR)) begin
                    unclosed = 1'b1;
                end
            end
            default: begin
                if (!blank) begin
                    if (c == wcs_pkg::C_SLASH && !last) begin
                        emit_raw = 1'b0;
                    end else begin
                        emit_raw = 1'b1;
                        stop_pos = cur_eff;
                    end
                end
            end
        endcase
    end

    assign stop_ext = {{FB{1'b0}}, stop_pos};

    assign o_result.emit_hold        = !done_eff && emit_raw;
    assign o_result.emit             = i_step && !done_eff && emit_raw;
    assign o_result.stop_offset      = stop_ext[FB-1:0];
    assign o_result.unclosed_comment = unclosed;

    assign n_done       = done_eff || emit_raw;
    assign n_cur_offset = done_eff ? cur_eff : pos_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= wcs_pkg::MODE_WS;
            r_cur_offset <= '0;
            r_done       <= 1'b0;
        end else if (i_step) begin
            r_mode       <= n_mode;
            r_cur_offset <= n_cur_offset;
            r_done       <= n_done;
        end
    end

    a_emit_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.emit |-> i_step)
        else $error("result raised without a step");

    a_silent_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_done && !i_item.first_byte) |-> !o_result.emit)
        else $error("second result within one run");

    a_offset_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !r_done && !i_item.first_byte) |=>
            (r_cur_offset == OFFSET_BITS'($past(r_cur_offset) + 1'b1)))
        else $error("position did not advance by one");

    a_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.emit) |=> r_done)
        else $error("run not closed after its result");

endmodule

[design/whitespace_comment_skipper_unit.sv]
// ----------------------------------------------------------------------------
// whitespace_comment_skipper_unit
// Skips blanks and C-style comments in a byte stream, reports token start.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                fields
//  in        sink       i_in_valid / o_in_stall  text_byte first_byte start_offset last_byte
//  out       source     o_out_valid / i_out_stall stop_offset unclosed_comment
//  cfg       sink       i_cfg_we                 skip_newlines (i_cfg_wdata)
//
//  one byte per cycle sustained unless a held result stalls the scanner; each result passes
//  through the input register, then scan mode logic into the result register
//  the mode/position registers feed back into their own update logic, which sets the one-byte rate
//  reset: mode whitespace, position zero, skip_newlines set, both registers empty
//  a held result stalls the scanner only when the byte being scanned gives a result
// ----------------------------------------------------------------------------
module whitespace_comment_skipper_unit #(
    parameter int unsigned OFFSET_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_first_byte,
    input  logic [31:0] i_start_offset,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_stop_offset,
    output logic        o_unclosed_comment
);

    logic               r_skip_nl;
    logic               r_out_valid;
    logic [31:0]        r_out_stop;
    logic               r_out_unclosed;

    wcs_pkg::t_item     in_item;
    wcs_pkg::t_in_word  in_word;
    wcs_pkg::t_result   scan_res;
    logic               out_free;
    logic               step;

    assign in_item.text_byte    = i_text_byte;
    assign in_item.first_byte   = i_first_byte;
    assign in_item.start_offset = i_start_offset;
    assign in_item.last_byte    = i_last_byte;

    // bytes with no result never need the output register
    assign out_free = !r_out_valid || !i_out_stall;

    wcs_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (in_item),
        .i_advance (step),
        .o_word    (in_word)
    );

    wcs_scan_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_item    (in_word.item),
        .i_skip_nl (r_skip_nl),
        .o_result  (scan_res)
    );

    // a step either carries no result, or finds room for it
    assign step = in_word.valid && (out_free || !scan_res.emit_hold);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_nl   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_skip_nl <= i_cfg_wdata;
            end
            if (scan_res.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_res.emit) begin
            r_out_stop     <= scan_res.stop_offset;
            r_out_unclosed <= scan_res.unclosed_comment;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_stop_offset      = r_out_stop;
    assign o_unclosed_comment = r_out_unclosed;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_res.emit |-> out_free)
        else $error("result register overwritten while held");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Scoreboard test of the whitespace and comment skipper. Byte runs (blanks,
// line and block comments, tokens, stray slashes, noise) are driven with
// random gaps and result stalls. A behavioural scanner in the scoreboard
// predicts the stop position of each run and checks every result word.
// ----------------------------------------------------------------------------
module tb;
    import wcs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;

    class skip_scoreboard;
        t_mode       mode;
        logic [31:0] pos_next;
        bit          done;
        bit          skip_nl;
        logic [32:0] stop_q[$];   // {unclosed_comment, stop_offset}
        int          errors;

        function new();
            mode     = MODE_WS;
            pos_next = '0;
            done     = 1'b0;
            skip_nl  = 1'b1;
            errors   = 0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return (c inside {C_SPACE, C_TAB, C_CR, C_FF, C_VT}) || (c == C_NL && skip_nl);
        endfunction

        function void push_stop(logic [31:0] stop, bit unclosed);
            stop_q.push_back({unclosed, stop});
            done = 1'b1;
        endfunction

        function void flag_error(string what, logic [32:0] want, logic [32:0] got);
            errors++;
            if (errors <= 10) begin
                $display("%s: expected stop %h unclosed %b, got stop %h unclosed %b",
                         what, want[31:0], want[32], got[31:0], got[32]);
            end
        endfunction

        // one accepted input word through the scanner
        function void note_byte(logic [7:0] c, bit first, logic [31:0] start, bit last);
            logic [31:0] cur;
            logic [31:0] nxt;
            if (first) begin
                pos_next = start;
                mode     = MODE_WS;
                done     = 1'b0;
            end
            if (done) return;
            cur      = pos_next;
            nxt      = cur + 32'd1;
            pos_next = nxt;
            case (mode)
                MODE_SLASH: begin
                    if (c == C_SLASH) begin
                        mode = MODE_LINE;
                        if (last) push_stop(nxt, 1'b0);
                    end else if (c == C_STAR) begin
                        mode = MODE_BLOCK;
                        if (last) push_stop(nxt, 1'b1);
                    end else begin
                        // the slash itself is the token
                        push_stop(cur - 32'd1, 1'b0);
                    end
                end
                MODE_LINE, MODE_LINE_BS: begin
                    if (c == C_NL) begin
                        if (mode == MODE_LINE_BS) begin
                            mode = MODE_LINE;
                        end else if (skip_nl) begin
                            mode = MODE_WS;
                        end else begin
                            push_stop(cur, 1'b0);
                            return;
                        end
                    end else begin
                        mode = (c == C_BACKSLASH) ? MODE_LINE_BS : MODE_LINE;
                    end
                    if (last) push_stop(nxt, 1'b0);
                end
                MODE_BLOCK, MODE_BLOCK_STAR: begin
                    if (c == C_SLASH && mode == MODE_BLOCK_STAR) begin
                        mode = MODE_WS;
                        if (last) push_stop(nxt, 1'b0);
                    end else begin
                        mode = (c == C_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
                        if (last) push_stop(nxt, 1'b1);
                    end
                end
                default: begin
                    mode = MODE_WS;
                    if (is_blank(c)) begin
                        if (last) push_stop(nxt, 1'b0);
                    end else if (c == C_SLASH && !last) begin
                        mode = MODE_SLASH;
                    end else begin
                        push_stop(cur, 1'b0);
                    end
                end
            endcase
        endfunction

        function void check_result(logic [31:0] stop, logic unclosed);
            logic [32:0] want;
            if (stop_q.size() == 0) begin
                flag_error("unexpected result", 'x, {unclosed, stop});
                return;
            end
            want = stop_q.pop_front();
            if (want !== {unclosed, stop}) flag_error("mismatch", want, {unclosed, stop});
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_text_byte = '0;
    logic        i_first_byte = 1'b0;
    logic [31:0] i_start_offset = '0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_stop_offset;
    logic        o_unclosed_comment;

    skip_scoreboard sb = new();
    int cycles = 0;
    int items_sent = 0;
    int hold_cycles = 0;
    bit no_idle = 1'b0;

    whitespace_comment_skipper_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_text_byte        (i_text_byte),
        .i_first_byte       (i_first_byte),
        .i_start_offset     (i_start_offset),
        .i_last_byte        (i_last_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_stop_offset      (o_stop_offset),
        .o_unclosed_comment (o_unclosed_comment)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] c, bit first, logic [31:0] start, bit last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_text_byte    <= c;
        i_first_byte   <= first;
        i_start_offset <= start;
        i_last_byte    <= last;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.note_byte(c, first, start, last);
        items_sent++;
    endtask

    // the upper-case letters N, T, R, F, V and B stand for control bytes in directed text
    function automatic logic [7:0] decode(byte ch);
        case (ch)
            "N":     return C_NL;
            "T":     return C_TAB;
            "R":     return C_CR;
            "F":     return C_FF;
            "V":     return C_VT;
            "B":     return C_BACKSLASH;
            default: return 8'(ch);
        endcase
    endfunction

    task automatic send_text(string s, bit first, logic [31:0] start, bit last);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(decode(s[i]), first && i == 0, (i == 0) ? start : $urandom,
                      last && i == s.len() - 1);
        end
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (sb.stop_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_skip_nl(bit value);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.skip_nl = value;
    endtask

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 5))
            0:       return C_SPACE;
            1:       return C_TAB;
            2:       return C_CR;
            3:       return C_FF;
            4:       return C_VT;
            default: return C_NL;
        endcase
    endfunction

    function automatic logic [7:0] rand_comment_byte();
        case ($urandom_range(0, 6))
            0:       return C_STAR;
            1:       return C_SLASH;
            2:       return C_BACKSLASH;
            3:       return C_NL;
            4:       return C_SPACE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_run();
        logic [7:0]  txt[$];
        logic [31:0] start;
        int          ending;
        int          n;
        bit          mark_last;
        start = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFF8 + $urandom_range(0, 7) : $urandom;
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 3))
                0: repeat ($urandom_range(1, 3)) txt.push_back(rand_blank());
                1: begin
                    txt.push_back(C_SLASH);
                    txt.push_back(C_SLASH);
                    repeat ($urandom_range(0, 4)) txt.push_back(rand_comment_byte());
                    if ($urandom_range(0, 2) == 0) begin
                        // continued line comment
                        txt.push_back(C_BACKSLASH);
                        txt.push_back(C_NL);
                        repeat ($urandom_range(0, 3)) txt.push_back(rand_comment_byte());
                    end
                    txt.push_back(C_NL);
                end
                2: begin
                    txt.push_back(C_SLASH);
                    txt.push_back(C_STAR);
                    repeat ($urandom_range(0, 5)) txt.push_back(rand_comment_byte());
                    txt.push_back(C_STAR);
                    txt.push_back(C_SLASH);
                end
                default: txt.push_back(C_NL);
            endcase
        end
        ending = $urandom_range(0, 3);
        mark_last = ending >= 2;
        case (ending)
            0: txt.push_back(8'($urandom_range(0, 255)));
            1: begin
                txt.push_back(C_SLASH);
                txt.push_back(8'($urandom_range(0, 255)));
            end
            3: begin
                // cut the text short, often inside a comment
                n = $urandom_range(0, 2);
                while (n > 0 && txt.size() > 1) begin
                    void'(txt.pop_back());
                    n--;
                end
            end
            default: ;
        endcase
        if (txt.size() == 0) txt.push_back(rand_blank());
        foreach (txt[i]) begin
            send_byte(txt[i], i == 0, (i == 0) ? start : $urandom,
                      mark_last && i == txt.size() - 1);
        end
        // trailing words, normally ignored
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                send_byte(8'($urandom_range(0, 255)), 1'b0, $urandom, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic random_phase(int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(0, 4) == 0) begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, $urandom,
                          $urandom_range(0, 3) == 0);
            end else begin
                send_random_run();
            end
        end
    endtask

    initial begin : receiver
        int k;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            k = no_idle ? 0 : $urandom_range(0, 8);
            repeat (k) begin
                i_out_stall <= 1'b1;
                @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            sb.check_result(o_stop_offset, o_unclosed_comment);
        end
    end

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // run with no first mark straight after reset starts at zero
        send_text(" T/x", 1'b0, '0, 1'b0);
        send_text("   ", 1'b1, 32'hFFFF_FFFE, 1'b1);
        send_text("/", 1'b1, 32'd7, 1'b1);
        // opener star cannot close the comment
        send_text("/*/", 1'b1, 32'd100, 1'b1);
        send_text("//aBNqNz", 1'b1, 32'd200, 1'b0);
        send_text("y", 1'b0, '0, 1'b1);
        send_text("/*R**/FV;", 1'b1, 32'h8000_0000, 1'b0);
        send_byte(8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
        send_text("/+", 1'b1, 32'h7FFF_FFFF, 1'b0);
        send_byte(8'h00, 1'b1, '0, 1'b0);
        send_text("//", 1'b1, 32'd50, 1'b1);

        write_skip_nl(1'b0);
        send_text("N", 1'b1, 32'd300, 1'b0);
        send_text("//aN", 1'b1, 32'd400, 1'b0);
        send_text("//BNN", 1'b1, 32'd500, 1'b0);

        write_skip_nl(1'b1);
        random_phase(150);

        // long result hold while the sender keeps offering single-word runs
        wait_drain();
        no_idle = 1'b1;
        hold_cycles = 300;
        repeat (40) send_byte(8'h61 + 8'($urandom_range(0, 25)), 1'b1, $urandom, 1'b0);
        no_idle = 1'b0;

        write_skip_nl(1'b0);
        no_idle = 1'b1;
        random_phase(150);
        no_idle = 1'b0;

        write_skip_nl(1'b1);
        random_phase(200);

        wait_drain();
        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
